// ===== design/sqpc_pkg.sv =====
// sqpc_pkg: shared types, constants and the microcode table of the subleq core
package sqpc_pkg;

    // field widths
    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 14;
    localparam int WORD_W      = 32;
    localparam int ST_W        = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 72;
    localparam int M_PAD_W     = M_TDATA_W - 2 * WORD_W - ST_W;
    localparam int STEP_W      = 4;

    // machine constants
    localparam int                MEM_WORDS_DEF = 16384;
    localparam logic [WORD_W-1:0] HALT_LIMIT    = WORD_W'(9997);
    localparam logic [ADDR_W-1:0] RESET_START   = ADDR_W'(9);
    localparam logic [WORD_W-1:0] INSN_WORDS    = WORD_W'(3);

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_EXEC    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_RUN   = 2'd0,
        ST_HALT  = 2'd1,
        ST_FAULT = 2'd2
    } t_status;

    // microcode addresses
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_IDLE = 4'd0;
    localparam t_step STEP_WR   = 4'd1;
    localparam t_step STEP_RD   = 4'd2;
    localparam t_step STEP_RD2  = 4'd3;
    localparam t_step STEP_EX0  = 4'd4;
    localparam t_step STEP_EX1  = 4'd5;
    localparam t_step STEP_EX2  = 4'd6;
    localparam t_step STEP_EX3  = 4'd7;
    localparam t_step STEP_EX4  = 4'd8;
    localparam t_step STEP_EX5  = 4'd9;
    localparam t_step STEP_RS   = 4'd10;
    localparam t_step STEP_FIN  = 4'd11;

    // memory address source
    typedef enum logic [2:0] {
        AS_HOST, AS_PC0, AS_PC1, AS_PC2, AS_A, AS_B
    } t_asel;

    // register load target, fed from the memory read data
    typedef enum logic [2:0] {
        LD_NONE, LD_A, LD_B, LD_C, LD_MB, LD_RD
    } t_ld;

    // memory write source
    typedef enum logic [1:0] {
        WR_NONE, WR_HOST, WR_RES
    } t_wr;

    // counter operation
    typedef enum logic [1:0] {
        OP_NONE, OP_PC_UPD, OP_RESTART
    } t_op;

    // sequencing condition
    typedef enum logic [2:0] {
        CD_DISPATCH, CD_GO, CD_EXEC_CHK, CD_B_CHK, CD_A_CHK, CD_OUT
    } t_cond;

    typedef struct packed {
        t_asel asel;
        t_ld   ld;
        t_wr   wr;
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_uword uw;
        logic   accept;
        logic   set_fault;
        logic   out_load;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic skip;
        logic pc_bad;
        logic b_bad;
        logic a_bad;
        logic out_free;
    } t_flags;

    // microcode table
    function automatic t_uword ucode_rom(input t_step step);
        t_uword uw;
        uw = '{asel: AS_HOST, ld: LD_NONE, wr: WR_NONE, op: OP_NONE,
               cond: CD_GO, target: STEP_FIN};
        case (step)
            STEP_IDLE: begin
                uw.cond   = CD_DISPATCH;
                uw.target = STEP_IDLE;
            end
            STEP_WR:   uw.wr = WR_HOST;
            STEP_RD:   uw.target = STEP_RD2;
            STEP_RD2:  uw.ld = LD_RD;
            STEP_EX0: begin
                uw.asel   = AS_PC0;
                uw.cond   = CD_EXEC_CHK;
                uw.target = STEP_EX1;
            end
            STEP_EX1: begin
                uw.asel   = AS_PC1;
                uw.ld     = LD_A;
                uw.target = STEP_EX2;
            end
            STEP_EX2: begin
                uw.asel   = AS_PC2;
                uw.ld     = LD_B;
                uw.target = STEP_EX3;
            end
            STEP_EX3: begin
                uw.asel   = AS_B;
                uw.ld     = LD_C;
                uw.cond   = CD_B_CHK;
                uw.target = STEP_EX4;
            end
            STEP_EX4: begin
                uw.asel   = AS_A;
                uw.ld     = LD_MB;
                uw.cond   = CD_A_CHK;
                uw.target = STEP_EX5;
            end
            STEP_EX5: begin
                uw.asel = AS_B;
                uw.wr   = WR_RES;
                uw.op   = OP_PC_UPD;
            end
            STEP_RS:   uw.op = OP_RESTART;
            STEP_FIN: begin
                uw.cond   = CD_OUT;
                uw.target = STEP_IDLE;
            end
            default:   uw.target = STEP_IDLE;
        endcase
        return uw;
    endfunction

endpackage

// ===== design/sqpc_useq.sv =====
// sqpc_useq: step counter and microcode sequencer of the subleq core
module sqpc_useq import sqpc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_cmd   i_cmd,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl,
    output logic   o_in_ready
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    logic   w_accept;
    logic   w_set_fault;
    logic   w_out_load;

    // control word of the current step, no request taken while in reset
    assign w_uw       = ucode_rom(r_step);
    assign o_in_ready = (r_step == STEP_IDLE) && i_rst_n;

    // next step and side effects of the condition
    always_comb begin
        n_step      = r_step;
        w_accept    = 1'b0;
        w_set_fault = 1'b0;
        w_out_load  = 1'b0;
        case (w_uw.cond)
            CD_DISPATCH: begin
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    case (i_cmd)
                        CMD_WRITE: n_step = STEP_WR;
                        CMD_READ:  n_step = STEP_RD;
                        CMD_EXEC:  n_step = STEP_EX0;
                        default:   n_step = STEP_RS;
                    endcase
                end
            end
            CD_GO: n_step = w_uw.target;
            CD_EXEC_CHK: begin
                if (i_flags.skip) begin
                    n_step = STEP_FIN;
                end else if (i_flags.pc_bad) begin
                    n_step      = STEP_FIN;
                    w_set_fault = 1'b1;
                end else begin
                    n_step = w_uw.target;
                end
            end
            CD_B_CHK: begin
                if (i_flags.b_bad) begin
                    n_step      = STEP_FIN;
                    w_set_fault = 1'b1;
                end else begin
                    n_step = w_uw.target;
                end
            end
            CD_A_CHK: begin
                if (i_flags.a_bad) begin
                    n_step      = STEP_FIN;
                    w_set_fault = 1'b1;
                end else begin
                    n_step = w_uw.target;
                end
            end
            CD_OUT: begin
                if (i_flags.out_free) begin
                    n_step     = w_uw.target;
                    w_out_load = 1'b1;
                end
            end
            default: n_step = STEP_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = '{uw: w_uw, accept: w_accept, set_fault: w_set_fault,
                      out_load: w_out_load};

endmodule

// ===== design/sqpc_datapath.sv =====
// sqpc_datapath: word memory, machine registers and result register of the subleq core
module sqpc_datapath import sqpc_pkg::*; #(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [WORD_W-1:0]    i_data,
    input  logic                 i_cfg_wr_en,
    input  logic [ADDR_W-1:0]    i_cfg_wr_data,
    input  logic                 i_out_ready,
    output t_flags               o_flags,
    output logic                 o_out_valid,
    output logic [M_TDATA_W-1:0] o_out_data
);

    localparam int                IDX_W   = $clog2(MEM_WORDS);
    localparam logic [WORD_W-1:0] MEM_LIM = WORD_W'(MEM_WORDS);

    logic [WORD_W-1:0]    mem [MEM_WORDS];

    logic [WORD_W-1:0]    r_pc;
    logic                 r_fault;
    logic [ADDR_W-1:0]    r_start;
    logic [ADDR_W-1:0]    r_addr;
    logic [WORD_W-1:0]    r_data;
    logic [WORD_W-1:0]    r_a;
    logic [WORD_W-1:0]    r_b;
    logic [WORD_W-1:0]    r_c;
    logic [WORD_W-1:0]    r_mb;
    logic [WORD_W-1:0]    r_rd;
    logic [WORD_W-1:0]    r_q;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [WORD_W-1:0]    n_pc;
    logic [WORD_W-1:0]    w_host_addr;
    logic                 w_host_in;
    logic [WORD_W-1:0]    w_pc1;
    logic [WORD_W-1:0]    w_pc2;
    logic                 w_halted;
    logic [WORD_W-1:0]    w_maddr;
    logic [IDX_W-1:0]     w_idx;
    logic [WORD_W-1:0]    w_sub;
    logic [WORD_W-1:0]    w_res;
    logic                 w_res_nonpos;
    logic                 w_mem_we;
    logic [WORD_W-1:0]    w_wdata;
    t_status              w_status;

    // address checks and halt test
    assign w_host_addr = WORD_W'(r_addr);
    assign w_host_in   = (w_host_addr < MEM_LIM);
    assign w_pc1       = r_pc + WORD_W'(1);
    assign w_pc2       = r_pc + WORD_W'(2);
    assign w_halted    = r_pc[WORD_W-1] || (r_pc >= HALT_LIMIT);

    assign o_flags = '{skip:     r_fault || w_halted,
                       pc_bad:   (w_pc2 >= MEM_LIM),
                       b_bad:    (r_b >= MEM_LIM),
                       a_bad:    !r_a[WORD_W-1] && (r_a >= MEM_LIM),
                       out_free: !r_out_valid || i_out_ready};

    // memory address select
    always_comb begin
        case (i_ctrl.uw.asel)
            AS_HOST: w_maddr = w_host_addr;
            AS_PC0:  w_maddr = r_pc;
            AS_PC1:  w_maddr = w_pc1;
            AS_PC2:  w_maddr = w_pc2;
            AS_A:    w_maddr = r_a;
            AS_B:    w_maddr = r_b;
            default: w_maddr = r_pc;
        endcase
    end
    assign w_idx = w_maddr[IDX_W-1:0];

    // subtract and branch test
    assign w_sub        = r_a[WORD_W-1] ? r_a : r_q;
    assign w_res        = r_mb - w_sub;
    assign w_res_nonpos = (w_res == '0) || w_res[WORD_W-1];

    // memory write source
    always_comb begin
        case (i_ctrl.uw.wr)
            WR_HOST: begin
                w_mem_we = w_host_in;
                w_wdata  = r_data;
            end
            WR_RES: begin
                w_mem_we = 1'b1;
                w_wdata  = w_res;
            end
            default: begin
                w_mem_we = 1'b0;
                w_wdata  = w_res;
            end
        endcase
    end

    // single port word memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_idx] <= w_wdata;
        end
        r_q <= mem[w_idx];
    end

    // next program counter
    always_comb begin
        case (i_ctrl.uw.op)
            OP_PC_UPD:  n_pc = w_res_nonpos ? r_c : (r_pc + INSN_WORDS);
            OP_RESTART: n_pc = WORD_W'(r_start);
            default:    n_pc = r_pc;
        endcase
    end

    // result status
    always_comb begin
        if (r_fault) begin
            w_status = ST_FAULT;
        end else if (w_halted) begin
            w_status = ST_HALT;
        end else begin
            w_status = ST_RUN;
        end
    end

    // machine control state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= WORD_W'(RESET_START);
            r_fault     <= 1'b0;
            r_start     <= RESET_START;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_ctrl.uw.op == OP_RESTART) begin
                r_fault <= 1'b0;
            end else if (i_ctrl.set_fault) begin
                r_fault <= 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_start <= i_cfg_wr_data;
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request fields, fetched operands and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_addr <= i_addr;
            r_data <= i_data;
        end
        case (i_ctrl.uw.ld)
            LD_A:    r_a  <= r_q;
            LD_B:    r_b  <= r_q;
            LD_C:    r_c  <= r_q;
            LD_MB:   r_mb <= r_q;
            default: ;
        endcase
        if (i_ctrl.accept) begin
            r_rd <= '0;
        end else if (i_ctrl.uw.ld == LD_RD) begin
            r_rd <= w_host_in ? r_q : '0;
        end
        if (i_ctrl.out_load) begin
            r_out_data <= {M_PAD_W'(0), w_status, r_pc, r_rd};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/subleq_processor_core_top.sv =====
// subleq_processor_core_top: top level of the microcoded subleq processor core
//
//  channel   | signals                         | contents
//  ----------+---------------------------------+----------------------------------------
//  request   | s_axis_tvalid/tready/tdata/tuser| tuser: command; tdata: address, data
//  result    | m_axis_tvalid/tready/tdata      | tdata: read_data, program_counter, status
//  config    | i_cfg_wr_en, i_cfg_wr_data      | start_address
//
//  a request is accepted only in the idle step, and the core takes no new request until it
//  is back there; an execute request makes six accesses to the single port word memory, one
//  per microcode step, and ends early when halted or faulting.
//  synchronous active low reset sets the step counter to idle, the counter register and
//  start address to 9, and clears fault flag and result valid; memory contents are kept.
//  a finished result waits in the output register while the next request is accepted and
//  worked on; that request stalls at its final step until the output register is free.
module subleq_processor_core_top import sqpc_pkg::*; #(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // address[13:0], data[45:14], zero[47:46]
    input  logic [CMD_W-1:0]     s_axis_tuser,   // command[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // read_data[31:0], program_counter[63:32],
                                                 // status[65:64], zero[71:66]
    input  logic                 i_cfg_wr_en,
    input  logic [ADDR_W-1:0]    i_cfg_wr_data
);

    t_ctrl  w_ctrl;
    t_flags w_flags;

    // microcode sequencer
    sqpc_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (t_cmd'(s_axis_tuser)),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl),
        .o_in_ready (s_axis_tready)
    );

    // memory and machine datapath
    sqpc_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_addr        (s_axis_tdata[ADDR_W-1:0]),
        .i_data        (s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_flags       (w_flags),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata)
    );

endmodule

// ===== design/sqpc_checker.sv =====
// sqpc_checker: port level assertions for the subleq core and their bind
module sqpc_checker import sqpc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // no result is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an accepted request keeps the core busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken on back to back cycles");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // halted status agrees with the reported counter
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[65:64] == ST_HALT))
            |-> (m_axis_tdata[63] || (m_axis_tdata[63:32] >= HALT_LIMIT)))
        else $error("halted status with counter in range");

    // running status agrees with the reported counter
    a_run_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[65:64] == ST_RUN))
            |-> (!m_axis_tdata[63] && (m_axis_tdata[63:32] < HALT_LIMIT)))
        else $error("running status with counter out of range");

endmodule

bind subleq_processor_core_top sqpc_checker u_sqpc_checker (.*);
